>>> sv/ack_bandwidth_estimator_assert.svh
// assertion helpers for the bandwidth estimator
// both sample on the rising edge of clk and stay quiet while rst_n is low
`ifndef ACK_BANDWIDTH_ESTIMATOR_ASSERT_SVH
`define ACK_BANDWIDTH_ESTIMATOR_ASSERT_SVH

// same-cycle implication
`define ABE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ABE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/abe_pkg.sv
`default_nettype none
package abe_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 6;

  localparam logic [15:0] MSS_RESET      = 16'd1460;
  localparam logic [15:0] FLOOR_RESET    = 16'd50;
  localparam logic [19:0] INIT_RTT_RESET = 20'd20000;
  localparam logic [31:0] MIN_WIN_FLOOR  = 32'd2;

  // ack event kinds
  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_FAST  = 3'd1,
    CMD_SLOW  = 3'd2,
    CMD_FRTO  = 3'd3,
    CMD_RTT   = 3'd4
  } abe_cmd_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MSS      = 2'd0,
    CFG_FLOOR    = 2'd1,
    CFG_INIT_RTT = 2'd2
  } abe_cfg_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SLOW,
    ST_DIV_BW,
    ST_SMOOTH,
    ST_MUL,
    ST_DIV_WIN,
    ST_DONE
  } abe_state_t;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } abe_unit_stat_t;

endpackage
`default_nettype wire

>>> sv/abe_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module abe_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [31:0]                dividend,
  input  wire logic [31:0]                divisor,
  output abe_pkg::abe_unit_stat_t         stat,
  output logic [31:0]                     quotient
);
  import abe_pkg::*;

  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  // trial subtract of the divisor from the shifted remainder
  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
        cnt_r  <= CNT_W'(DATA_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!diff[DATA_W]) begin
          rem_r <= diff[DATA_W-1:0];
          quo_r <= {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted[DATA_W-1:0];
          quo_r <= {quo_r[DATA_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule
`default_nettype wire

>>> sv/abe_mul.sv
`default_nettype none
// shift-add multiplier, low 32 bits of the product, one bit per cycle
module abe_mul (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [31:0]                op_a,
  input  wire logic [31:0]                op_b,
  output abe_pkg::abe_unit_stat_t         stat,
  output logic [31:0]                     product
);
  import abe_pkg::*;

  logic [DATA_W-1:0] acc_r;
  logic [DATA_W-1:0] mcand_r;
  logic [DATA_W-1:0] mplier_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        acc_r    <= '0;
        mcand_r  <= op_a;
        mplier_r <= op_b;
        cnt_r    <= CNT_W'(DATA_W);
        busy_r   <= 1'b1;
      end else if (busy_r) begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= {mcand_r[DATA_W-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[DATA_W-1:1]};
        cnt_r    <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = acc_r;

endmodule
`default_nettype wire

>>> sv/ack_bandwidth_estimator.sv
// ACK bandwidth estimator for one connection. Each ACK event (start, fast ack,
// slow ack, frto, rtt sample) yields one result: the smoothed bandwidth in bytes
// per tick, the minimum RTT and max(bw * min_rtt / mss, 2). One event is worked
// at a time; an event holds the block until its result is loaded, which takes
// longer when a fast ack closes the evaluation window, and the load also waits
// while the previous result is still held for out_tready. The time is set by the
// bit-serial arithmetic: a shift-add multiply and a restoring divide for the
// window figure, plus one more pass of the shared divider for bytes over elapsed
// ticks when the window closes. A finished result waits in the output register
// while the next event is taken. Configuration writes are always accepted and
// must only be issued while the block is idle.
`default_nettype none
`include "ack_bandwidth_estimator_assert.svh"
module ack_bandwidth_estimator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // ack events
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // now [31:0], ack_seq [63:32], rtt_sample [95:64]
  input  wire logic [2:0]  in_tuser,   // cmd [2:0]
  // results
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // bw_estimate [31:0], min_rtt [63:32], min_window [95:64]
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);
  import abe_pkg::*;

  abe_state_t state_r, state_nxt;

  // configuration
  logic [15:0] mss_r;
  logic [15:0] floor_r;
  logic [19:0] init_rtt_r;

  // latched request
  logic [2:0]  cmd_r;
  logic [31:0] now_r;
  logic [31:0] ack_r;
  logic [31:0] smp_r;

  // connection state
  logic [31:0] raw_bw_r;
  logic [31:0] smooth_bw_r;
  logic [31:0] window_start_r;
  logic [31:0] window_bytes_r;
  logic [31:0] last_ack_r;
  logic [31:0] dup_credit_r;
  logic [31:0] cur_rtt_r;
  logic [31:0] low_rtt_r;
  logic        first_pending_r;
  logic        recapture_r;
  logic [31:0] slow_acked_r;
  logic [31:0] win_r;

  // result register
  logic        out_tvalid_r;
  logic [31:0] out_bw_r;
  logic [31:0] out_rtt_r;
  logic [31:0] out_win_r;

  // arithmetic units
  abe_unit_stat_t div_stat;
  abe_unit_stat_t mul_stat;
  logic           div_start;
  logic           mul_start;
  logic [31:0]    div_dividend;
  logic [31:0]    div_divisor;
  logic [31:0]    div_q;
  logic [31:0]    mul_p;

  // window close decision
  logic [31:0] span;
  logic [31:0] limit;
  logic        close_win;
  logic [31:0] last_eff;
  logic [31:0] delta;
  logic [31:0] mss_ext;
  logic        out_free;

  function automatic logic [31:0] lowpass(input logic [31:0] old, input logic [31:0] smp);
    logic [31:0] mix;
    mix = {old[28:0], 3'b000} - old + smp;
    return {3'b000, mix[31:3]};
  endfunction

  assign mss_ext   = {16'd0, mss_r};
  assign span      = now_r - window_start_r;
  assign limit     = (cur_rtt_r > {16'd0, floor_r}) ? cur_rtt_r : {16'd0, floor_r};
  assign close_win = (cur_rtt_r != 32'd0) && (span > limit);
  assign last_eff  = first_pending_r ? ack_r : last_ack_r;
  assign delta     = ack_r - last_eff;
  assign out_free  = !out_tvalid_r || out_tready;

  // shared divider operand select
  assign div_dividend = (state_r == ST_EXEC) ? window_bytes_r : mul_p;
  assign div_divisor  = (state_r == ST_EXEC) ? span : mss_ext;

  abe_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_q)
  );

  abe_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (smooth_bw_r),
    .op_b    (low_rtt_r),
    .stat    (mul_stat),
    .product (mul_p)
  );

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and unit starts
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd_r == CMD_FAST && close_win) begin
          div_start = 1'b1;
          state_nxt = ST_DIV_BW;
        end else if (cmd_r == CMD_SLOW) begin
          state_nxt = ST_SLOW;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_SLOW: begin
        state_nxt = ST_MUL;
      end
      ST_DIV_BW: begin
        if (div_stat.done) begin
          state_nxt = (raw_bw_r == 32'd0 && smooth_bw_r == 32'd0) ? ST_MUL : ST_SMOOTH;
        end
      end
      ST_SMOOTH: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        // first cycle here starts the multiply on settled operands
        if (!mul_stat.busy && !mul_stat.done) begin
          mul_start = 1'b1;
        end else if (mul_stat.done) begin
          div_start = 1'b1;
          state_nxt = ST_DIV_WIN;
        end
      end
      ST_DIV_WIN: begin
        if (div_stat.done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mss_r           <= MSS_RESET;
      floor_r         <= FLOOR_RESET;
      init_rtt_r      <= INIT_RTT_RESET;
      raw_bw_r        <= '0;
      smooth_bw_r     <= '0;
      window_start_r  <= '0;
      window_bytes_r  <= '0;
      last_ack_r      <= '0;
      dup_credit_r    <= '0;
      cur_rtt_r       <= {12'd0, INIT_RTT_RESET};
      low_rtt_r       <= {12'd0, INIT_RTT_RESET};
      first_pending_r <= 1'b1;
      recapture_r     <= 1'b1;
      out_tvalid_r    <= 1'b0;
    end else begin
      // register writes
      if (cfg_valid) begin
        case (cfg_index)
          CFG_MSS:      mss_r      <= cfg_data[15:0];
          CFG_FLOOR:    floor_r    <= cfg_data[15:0];
          CFG_INIT_RTT: init_rtt_r <= cfg_data;
          default: ;
        endcase
      end

      // result valid: load a new result or drop the accepted one
      if (state_r == ST_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd_r <= in_tuser;
            now_r <= in_tdata[31:0];
            ack_r <= in_tdata[63:32];
            smp_r <= in_tdata[95:64];
          end
        end
        ST_EXEC: begin
          case (cmd_r)
            CMD_START: begin
              raw_bw_r        <= '0;
              smooth_bw_r     <= '0;
              window_bytes_r  <= '0;
              dup_credit_r    <= '0;
              recapture_r     <= 1'b1;
              cur_rtt_r       <= {12'd0, init_rtt_r};
              low_rtt_r       <= {12'd0, init_rtt_r};
              window_start_r  <= now_r;
              last_ack_r      <= ack_r;
              first_pending_r <= 1'b1;
            end
            CMD_FAST: begin
              first_pending_r <= 1'b0;
              if (close_win) begin
                window_bytes_r <= delta;
                window_start_r <= now_r;
              end else begin
                window_bytes_r <= window_bytes_r + delta;
              end
              last_ack_r <= ack_r;
              if (recapture_r || cur_rtt_r < low_rtt_r) begin
                low_rtt_r <= cur_rtt_r;
              end
              recapture_r <= 1'b0;
            end
            CMD_SLOW: begin
              // duplicate ack counts one segment of credit
              if (ack_r == last_ack_r) begin
                dup_credit_r <= dup_credit_r + mss_ext;
                slow_acked_r <= mss_ext;
              end else begin
                slow_acked_r <= ack_r - last_ack_r;
              end
              last_ack_r <= ack_r;
              if (recapture_r || cur_rtt_r < low_rtt_r) begin
                low_rtt_r <= cur_rtt_r;
              end
              recapture_r <= 1'b0;
            end
            CMD_FRTO: begin
              recapture_r <= 1'b1;
            end
            CMD_RTT: begin
              if (smp_r != 32'd0 && !smp_r[31]) begin
                cur_rtt_r <= smp_r;
              end
            end
            default: ;
          endcase
        end
        ST_SLOW: begin
          // delayed ack accounting against the credit
          if (slow_acked_r > mss_ext) begin
            if (dup_credit_r >= slow_acked_r) begin
              dup_credit_r   <= dup_credit_r - slow_acked_r;
              window_bytes_r <= window_bytes_r + mss_ext;
            end else begin
              dup_credit_r   <= '0;
              window_bytes_r <= window_bytes_r + (slow_acked_r - dup_credit_r);
            end
          end else begin
            window_bytes_r <= window_bytes_r + slow_acked_r;
          end
        end
        ST_DIV_BW: begin
          if (div_stat.done) begin
            if (raw_bw_r == 32'd0 && smooth_bw_r == 32'd0) begin
              raw_bw_r    <= div_q;
              smooth_bw_r <= div_q;
            end else begin
              raw_bw_r <= lowpass(raw_bw_r, div_q);
            end
          end
        end
        ST_SMOOTH: begin
          smooth_bw_r <= lowpass(smooth_bw_r, raw_bw_r);
        end
        ST_DIV_WIN: begin
          // held apart from the output so a waiting result stays stable
          if (div_stat.done) begin
            win_r <= (div_q < MIN_WIN_FLOOR) ? MIN_WIN_FLOOR : div_q;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_bw_r  <= smooth_bw_r;
            out_rtt_r <= low_rtt_r;
            out_win_r <= win_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_win_r, out_rtt_r, out_bw_r};

  // checks
  `ABE_ASSERT_NEXT(a_busy_after_req, in_tvalid && in_tready, !in_tready, "took a second request while busy")
  `ABE_ASSERT_NOW(a_win_floor, out_tvalid_r, out_win_r >= MIN_WIN_FLOOR, "window below floor")
  `ABE_ASSERT_NOW(a_div_done_state, div_stat.done, state_r == ST_DIV_BW || state_r == ST_DIV_WIN, "divider finished outside a divide step")
  `ABE_ASSERT_NOW(a_units_exclusive, mul_stat.busy, !div_stat.busy, "multiplier and divider busy together")

endmodule
`default_nettype wire

>>> dv/abe_estimate_compare.sv
`timescale 1ns / 100ps

// watches the event, result and configuration channels of the bandwidth
// estimator, keeps its own copy of the estimator state and compares every
// result with the estimate worked out when the matching request went in
module abe_estimate_compare (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output int          mismatch_count,
  output int          pending_estimates,
  output int          window_closes,
  output int          estimates_checked
);
  import abe_pkg::*;

  localparam logic [31:0] FILTER_KEEP  = 32'd7;
  localparam int          FILTER_SHIFT = 3;
  localparam int          REPORT_LIMIT = 10;

  // bw_estimate sits in the low word, as on out_tdata
  typedef struct packed {
    logic [31:0] min_window;
    logic [31:0] min_rtt;
    logic [31:0] bw;
  } estimate_t;

  estimate_t   expected_estimates[$];

  // register copies
  logic [31:0] seg_size;
  logic [31:0] floor_ticks;
  logic [31:0] start_rtt;

  // estimator state
  logic [31:0] raw_bw;
  logic [31:0] smooth_bw;
  logic [31:0] win_start;
  logic [31:0] win_bytes;
  logic [31:0] last_seq;
  logic [31:0] dup_credit;
  logic [31:0] cur_rtt;
  logic [31:0] low_rtt;
  logic        seq_unset;
  logic        recapture;

  // one 7/8 low-pass stage, sum wraps before the shift
  function automatic logic [31:0] lowpass7(input logic [31:0] prev, input logic [31:0] bw_in);
    logic [31:0] sum;
    sum = FILTER_KEEP * prev + bw_in;
    return sum >> FILTER_SHIFT;
  endfunction

  task automatic note_min_rtt();
    if (recapture) begin
      low_rtt = cur_rtt;
      recapture = 1'b0;
    end else if (cur_rtt < low_rtt) begin
      low_rtt = cur_rtt;
    end
  endtask

  // apply one ack event to the state and return the estimate it leaves
  task automatic step_estimator(input logic [2:0] cmd, input logic [31:0] now,
                                input logic [31:0] seq, input logic [31:0] rtt,
                                output estimate_t est);
    logic [31:0] span;
    logic [31:0] limit;
    logic [31:0] bw_in;
    logic [31:0] acked;
    logic [31:0] prod;
    case (cmd)
      CMD_START: begin
        raw_bw = '0;
        smooth_bw = '0;
        win_bytes = '0;
        dup_credit = '0;
        recapture = 1'b1;
        cur_rtt = start_rtt;
        low_rtt = start_rtt;
        win_start = now;
        last_seq = seq;
        seq_unset = 1'b1;
      end
      CMD_FAST: begin
        span = now - win_start;
        limit = (cur_rtt > floor_ticks) ? cur_rtt : floor_ticks;
        if (seq_unset) begin
          last_seq = seq;
          seq_unset = 1'b0;
        end
        // window closes once its span passes max(rtt, floor)
        if (cur_rtt != 0 && span > limit) begin
          bw_in = win_bytes / span;
          if (raw_bw == 0 && smooth_bw == 0) begin
            raw_bw = bw_in;
            smooth_bw = bw_in;
          end else begin
            raw_bw = lowpass7(raw_bw, bw_in);
            smooth_bw = lowpass7(smooth_bw, raw_bw);
          end
          win_bytes = '0;
          win_start = now;
          window_closes++;
        end
        win_bytes = win_bytes + (seq - last_seq);
        last_seq = seq;
        note_min_rtt();
      end
      CMD_SLOW: begin
        // duplicate and delayed ack accounting against the segment size
        acked = seq - last_seq;
        if (acked == 0) begin
          dup_credit = dup_credit + seg_size;
          acked = seg_size;
        end
        if (acked > seg_size) begin
          if (dup_credit >= acked) begin
            dup_credit = dup_credit - acked;
            acked = seg_size;
          end else begin
            acked = acked - dup_credit;
            dup_credit = '0;
          end
        end
        last_seq = seq;
        win_bytes = win_bytes + acked;
        note_min_rtt();
      end
      CMD_FRTO: begin
        recapture = 1'b1;
      end
      CMD_RTT: begin
        if (rtt != 0 && !rtt[31]) cur_rtt = rtt;
      end
      default: begin
      end
    endcase
    est.bw = smooth_bw;
    est.min_rtt = low_rtt;
    if (seg_size == 0) begin
      est.min_window = '1;
    end else begin
      prod = smooth_bw * low_rtt;
      est.min_window = prod / seg_size;
      if (est.min_window < MIN_WIN_FLOOR) est.min_window = MIN_WIN_FLOOR;
    end
  endtask

  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t  %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) flag(what, want, got);
  endtask

  always @(posedge clk) begin : watch
    estimate_t got;
    estimate_t want;
    estimate_t est;
    if (!rst_n) begin
      expected_estimates.delete();
      seg_size = {16'd0, MSS_RESET};
      floor_ticks = {16'd0, FLOOR_RESET};
      start_rtt = {12'd0, INIT_RTT_RESET};
      raw_bw = '0;
      smooth_bw = '0;
      win_start = '0;
      win_bytes = '0;
      last_seq = '0;
      dup_credit = '0;
      cur_rtt = start_rtt;
      low_rtt = start_rtt;
      seq_unset = 1'b1;
      recapture = 1'b1;
      mismatch_count = 0;
      window_closes = 0;
      estimates_checked = 0;
    end else begin
      // results first: a result never belongs to a request taken on the same edge
      if (out_tvalid && out_tready) begin
        got = estimate_t'(out_tdata);
        estimates_checked++;
        if (expected_estimates.size() == 0) begin
          flag("result with no request outstanding, bw_estimate", '0, got.bw);
        end else begin
          want = expected_estimates.pop_front();
          compare_field("bw_estimate", want.bw, got.bw);
          compare_field("min_rtt", want.min_rtt, got.min_rtt);
          compare_field("min_window", want.min_window, got.min_window);
        end
      end
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MSS:      seg_size = {16'd0, cfg_data[15:0]};
          CFG_FLOOR:    floor_ticks = {16'd0, cfg_data[15:0]};
          CFG_INIT_RTT: start_rtt = {12'd0, cfg_data};
          default: begin
          end
        endcase
      end
      // accepted ack event request
      if (in_tvalid && in_tready) begin
        step_estimator(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[95:64], est);
        expected_estimates.push_back(est);
      end
    end
    pending_estimates = expected_estimates.size();
  end

endmodule

>>> dv/ack_bandwidth_estimator_tb.sv
`timescale 1ns / 100ps

module ack_bandwidth_estimator_tb;
  import abe_pkg::*;

  // command and register codes the block ignores
  localparam logic [2:0] CMD_SPARE_A = 3'd5;
  localparam logic [2:0] CMD_SPARE_B = 3'd6;
  localparam logic [2:0] CMD_SPARE_C = 3'd7;
  localparam logic [1:0] CFG_SPARE   = 2'd3;

  localparam int PHASES          = 8;
  localparam int EVENTS_PER_PHASE = 44;
  localparam int DRAIN_CYCLES    = 250;
  localparam int CYCLE_LIMIT     = 600000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;   // now [31:0], ack_seq [63:32], rtt_sample [95:64]
  logic [2:0]  in_tuser;   // cmd [2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;  // bw_estimate [31:0], min_rtt [63:32], min_window [95:64]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;

  int          mismatch_count;
  int          pending_estimates;
  int          window_closes;
  int          estimates_checked;

  int          burst_left;
  int          ready_left;
  int          stall_left;
  int          cycle_count;
  int          events_sent;
  logic [31:0] t_now;
  logic [31:0] t_seq;
  logic [31:0] seg_bytes;

  ack_bandwidth_estimator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  abe_estimate_compare u_compare (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .pending_estimates(pending_estimates),
    .window_closes    (window_closes),
    .estimates_checked(estimates_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop if the block hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_estimates);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: short ready runs and stalls, now and then a long stall-free stretch
  always @(negedge clk) begin
    if (ready_left > 0) begin
      ready_left--;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 7) == 0) begin
        ready_left = $urandom_range(200, 600);
        stall_left = 0;
      end else begin
        ready_left = $urandom_range(0, 12);
        stall_left = $urandom_range(1, 25);
      end
      out_tready <= 1'b1;
    end
  end

  // one ack event request; bursts of back-to-back requests, random gaps between
  task automatic send_event(input logic [2:0] cmd, input logic [31:0] now,
                            input logic [31:0] seq, input logic [31:0] rtt);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 120)) @(negedge clk);
      else repeat ($urandom_range(1, 20)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {rtt, seq, now};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    events_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending_estimates != 0) @(negedge clk);
  endtask

  // byte advance of a cumulative ack, mostly zero to four segments plus up to 300 bytes
  function automatic logic [31:0] seq_advance();
    if ($urandom_range(0, 19) == 0) return $urandom;
    if (seg_bytes == 0) return $urandom_range(1, 5000);
    return seg_bytes * $urandom_range(0, 4) + $urandom_range(0, 300);
  endfunction

  // edge cases at reset settings
  task automatic directed_events();
    send_event(CMD_FAST, 32'd5, 32'd7, 32'd0);  // fast ack straight out of reset
    send_event(CMD_START, 32'd1000, 32'hFFFF_F000, 32'd0);
    send_event(CMD_RTT, 32'd1000, 32'd0, 32'd0);  // zero sample ignored
    send_event(CMD_RTT, 32'd1000, 32'd0, 32'hFFFF_FFFB);  // negative ignored
    send_event(CMD_RTT, 32'd1000, 32'd0, 32'h8000_0000);  // most negative
    send_event(CMD_RTT, 32'd1000, 32'd0, 32'h7FFF_FFFF);  // largest positive
    send_event(CMD_FAST, 32'd1010, 32'h0000_0388, 32'd0);  // first ack across seq wrap
    send_event(CMD_FAST, 32'd2000, 32'h0000_1000, 32'd0);  // huge rtt, no close
    send_event(CMD_RTT, 32'd2000, 32'd0, 32'd40);  // below the floor
    send_event(CMD_FAST, 32'd2100, 32'h0000_3000, 32'd0);  // close, seeds both stages
    send_event(CMD_SLOW, 32'd2110, 32'h0000_3000, 32'd0);  // duplicate
    send_event(CMD_SLOW, 32'd2120, 32'h0000_3000, 32'd0);  // duplicate
    send_event(CMD_SLOW, 32'd2130, 32'h0000_37D0, 32'd0);  // credit covers the jump
    send_event(CMD_SLOW, 32'd2140, 32'h0000_5EE0, 32'd0);  // jump beyond credit
    send_event(CMD_SLOW, 32'd2150, 32'h0000_62C8, 32'd0);  // under one segment
    send_event(CMD_FAST, 32'd2200, 32'h0000_6E80, 32'd0);  // close, low-pass
    send_event(CMD_FRTO, 32'd2200, 32'd0, 32'd0);
    send_event(CMD_RTT, 32'd2200, 32'd0, 32'd30);
    send_event(CMD_FAST, 32'd2300, 32'h0000_9000, 32'd0);  // min rtt recaptured
    send_event(CMD_FAST, 32'd500, 32'h0000_A000, 32'd0);  // time stamp behind window
    send_event(CMD_FAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(CMD_SPARE_A, $urandom, $urandom, $urandom);
    send_event(CMD_SPARE_B, $urandom, $urandom, $urandom);
    send_event(CMD_SPARE_C, $urandom, $urandom, $urandom);
    send_event(CMD_START, 32'hFFFF_FFFF, 32'd0, 32'd0);
  endtask

  // mostly well-formed connections: start, rtt samples, ack streams; some noise
  task automatic random_traffic(input int count);
    int kind;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      if (kind < 4) begin
        t_now = $urandom;
        t_seq = $urandom;
        send_event(CMD_START, t_now, t_seq, $urandom);
      end else if (kind < 10) begin
        send_event(CMD_RTT, t_now, $urandom,
                   ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(1, 300));
      end else if (kind < 13) begin
        send_event(CMD_FRTO, t_now, $urandom, $urandom);
      end else if (kind < 30) begin
        t_now = t_now + $urandom_range(0, 40);
        if ($urandom_range(0, 2) != 0) t_seq = t_seq + seq_advance();
        send_event(CMD_SLOW, t_now, t_seq, $urandom);
      end else if (kind < 93) begin
        if ($urandom_range(0, 39) == 0) t_now = t_now - $urandom_range(1, 1000);
        else t_now = t_now + $urandom_range(0, 60);
        t_seq = t_seq + seq_advance();
        send_event(CMD_FAST, t_now, t_seq, $urandom);
      end else begin
        send_event(3'($urandom_range(CMD_START, CMD_SPARE_C)), $urandom, $urandom, $urandom);
      end
    end
  endtask

  // register settings per phase, the extremes first
  task automatic set_registers(input int phase);
    logic [15:0] mss;
    logic [15:0] floor_val;
    logic [19:0] init_val;
    case (phase)
      0: begin
        mss = 16'hFFFF;
        floor_val = 16'd0;
        init_val = 20'd0;
      end
      1: begin
        mss = 16'd0;
        floor_val = 16'hFFFF;
        init_val = 20'hFFFFF;
      end
      2: begin
        mss = 16'd1;
        floor_val = 16'd1;
        init_val = 20'd1;
      end
      default: begin
        mss = 16'($urandom_range(200, 9000));
        floor_val = 16'($urandom_range(1, 300));
        init_val = 20'($urandom_range(20, 60000));
      end
    endcase
    // upper data bits are don't-care for the 16-bit registers
    write_reg(CFG_MSS, {4'($urandom), mss});
    write_reg(CFG_FLOOR, {4'($urandom), floor_val});
    write_reg(CFG_INIT_RTT, init_val);
    if (phase == 3) write_reg(CFG_SPARE, 20'($urandom));
    seg_bytes = {16'd0, mss};
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    burst_left = 0;
    ready_left = 0;
    stall_left = 0;
    cycle_count = 0;
    events_sent = 0;
    t_now = '0;
    t_seq = '0;
    seg_bytes = {16'd0, MSS_RESET};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    directed_events();
    random_traffic(EVENTS_PER_PHASE / 2);
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      set_registers(phase);
      t_now = $urandom;
      t_seq = $urandom;
      send_event(CMD_START, t_now, t_seq, $urandom);
      random_traffic(EVENTS_PER_PHASE);
    end
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d ack events over %0d register settings, %0d window closes",
             events_sent, PHASES + 1, window_closes);
    $display("%0d results compared, %0d mismatches", estimates_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
